/* rtl/uer_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

    // default build of the ranger
    localparam int NUM_SENSORS_DEF = 3;
    localparam int COUNT_WIDTH_DEF = 20;

    // fixed field widths
    localparam int TRIG_W   = 10;
    localparam int TIME_W   = 20;
    localparam int SCALE_W  = 16;
    localparam int DIST_W   = 24;
    localparam int CFG_W    = 20;
    localparam int LINES_W  = 3;

    // register reset values
    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 10'd10;
    localparam logic [TIME_W-1:0]  TIMEOUT_TICKS_RST = 20'd30000;
    localparam logic [TIME_W-1:0]  GAP_TICKS_RST     = 20'd60000;
    localparam logic [SCALE_W-1:0] CM_PER_TICK_RST   = 16'd1124;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_TIMEOUT_TICKS = 2'd1,
        REG_GAP_TICKS     = 2'd2,
        REG_CM_PER_TICK   = 2'd3
    } cfg_reg_t;

    // sequencer phases
    typedef enum logic [3:0] {
        PH_TRIGGER = 4'b0001,
        PH_WAIT    = 4'b0010,
        PH_MEASURE = 4'b0100,
        PH_GAP     = 4'b1000
    } phase_t;

    // attempt outcome
    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_OK       = 2'd1,
        ST_NO_RISE  = 2'd2,
        ST_TOO_LONG = 2'd3
    } status_t;

    // one result transaction, packed from the lowest bit up: trigger_lines,
    // active_sensor, measure_done, attempt_status, forward, left, right
    typedef struct packed {
        logic [DIST_W-1:0]  right_cm_q8;
        logic [DIST_W-1:0]  left_cm_q8;
        logic [DIST_W-1:0]  forward_cm_q8;
        status_t            attempt_status;
        logic               measure_done;
        logic [1:0]         active_sensor;
        logic [LINES_W-1:0] trigger_lines;
    } result_t;

endpackage

/* rtl/ultrasonic_echo_ranger.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Round-robin trigger / echo timing controller for a set of ultrasonic rangers.
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the time base carrying the sampled
// echo levels, and each produces exactly one result transaction. Sensors are
// served in turn: trigger pulse, wait for echo rise, count echo-high ticks,
// scale the count to centimetres (Q16.8, saturating) and store it on success,
// then a gap before the next sensor. The block takes one tick per clock: the
// whole update of phase, count and distance (one COUNT_WIDTH x 16 multiply and a
// saturate) sits between the state registers and the result register, and a
// new tick is accepted whenever the result register is empty or being drained.
// Register writes take effect from the next tick on.
module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int NUM_SENSORS = NUM_SENSORS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    // configuration write port
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,

    // tick stream in; tdata: echo_levels[2:0], zero pad
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,

    // result stream out; tdata: trigger_lines[2:0], active_sensor[4:3],
    // measure_done[5], attempt_status[7:6], forward_cm_q8[31:8],
    // left_cm_q8[55:32], right_cm_q8[79:56]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [79:0]         m_axis_tdata
);

    localparam int SW      = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int STORE_N = (NUM_SENSORS < LINES_W) ? NUM_SENSORS : LINES_W;
    localparam int LW      = (COUNT_WIDTH > TIME_W) ? COUNT_WIDTH : TIME_W;

    localparam logic [SW-1:0]          LAST_SENSOR = SW'(NUM_SENSORS - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX     = {COUNT_WIDTH{1'b1}};
    localparam logic [LW-1:0]          CNT_MAX_L   = LW'(CNT_MAX);
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE     = COUNT_WIDTH'(1);

    // configuration registers
    logic [TRIG_W-1:0]  trigger_ticks_reg;
    logic [TIME_W-1:0]  timeout_ticks_reg;
    logic [TIME_W-1:0]  gap_ticks_reg;
    logic [SCALE_W-1:0] cm_per_tick_reg;

    // sequencer state
    phase_t                 phase_reg, phase_next;
    logic [SW-1:0]          sensor_reg, sensor_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [DIST_W-1:0]      dist_reg [STORE_N];

    // result register
    logic    out_valid_reg;
    result_t out_reg, out_next;

    logic                   accept;
    logic                   echo;
    logic [LINES_W-1:0]     trig;
    logic [COUNT_WIDTH-1:0] trig_len;
    logic [COUNT_WIDTH-1:0] timeout_clip;
    logic [COUNT_WIDTH-1:0] gap_clip;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [47:0]            product;
    logic [DIST_W-1:0]      dist_new;
    logic                   store_en;
    status_t                status;
    logic [DIST_W-1:0]      dist_view [LINES_W];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= TRIGGER_TICKS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            gap_ticks_reg     <= GAP_TICKS_RST;
            cm_per_tick_reg   <= CM_PER_TICK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data[TRIG_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[TIME_W-1:0];
                REG_GAP_TICKS:     gap_ticks_reg     <= cfg_data[TIME_W-1:0];
                REG_CM_PER_TICK:   cm_per_tick_reg   <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // limits cut to the counter range, zero trigger length counts as one
    always_comb
    begin
        logic [LW-1:0] t_ext;
        logic [LW-1:0] to_ext;
        logic [LW-1:0] g_ext;
        t_ext  = LW'(trigger_ticks_reg);
        to_ext = LW'(timeout_ticks_reg);
        g_ext  = LW'(gap_ticks_reg);
        trig_len     = (t_ext < CNT_MAX_L) ? COUNT_WIDTH'(t_ext) : CNT_MAX;
        timeout_clip = (to_ext < CNT_MAX_L) ? COUNT_WIDTH'(to_ext) : CNT_MAX;
        gap_clip     = (g_ext < CNT_MAX_L) ? COUNT_WIDTH'(g_ext) : CNT_MAX;
        if (trig_len == '0)
        begin
            trig_len = CNT_ONE;
        end
    end

    // echo select and trigger drive for the sensor being served
    always_comb
    begin
        echo = 1'b0;
        trig = '0;
        for (int k = 0; k < LINES_W; k++)
        begin
            if (32'(sensor_reg) == k)
            begin
                echo    = s_axis_tdata[k];
                trig[k] = 1'b1;
            end
        end
    end

    // scale echo count to Q16.8 centimetres, saturating
    assign product   = 48'(count_reg) * 48'(cm_per_tick_reg);
    assign dist_new  = (|product[47:32]) ? DIST_MAX : product[31:8];
    assign count_inc = (count_reg < CNT_MAX) ? count_reg + CNT_ONE : count_reg;

    // phase sequencer
    always_comb
    begin
        logic attempt_end;
        logic to_next;
        phase_next  = phase_reg;
        sensor_next = sensor_reg;
        count_next  = count_reg;
        status      = ST_BUSY;
        store_en    = 1'b0;
        attempt_end = 1'b0;
        to_next     = 1'b0;

        case (phase_reg)
            PH_TRIGGER:
            begin
                count_next = count_inc;
                if (count_inc >= trig_len)
                begin
                    phase_next = PH_WAIT;
                    count_next = '0;
                end
            end
            PH_WAIT:
            begin
                if (echo)
                begin
                    if (timeout_clip != '0)
                    begin
                        phase_next = PH_MEASURE;
                        count_next = CNT_ONE;
                    end
                    else
                    begin
                        status      = ST_TOO_LONG;
                        attempt_end = 1'b1;
                    end
                end
                else if (count_reg >= timeout_clip)
                begin
                    status      = ST_NO_RISE;
                    attempt_end = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                end
            end
            PH_MEASURE:
            begin
                if (!echo)
                begin
                    store_en    = 1'b1;
                    status      = ST_OK;
                    attempt_end = 1'b1;
                end
                else if (count_reg >= timeout_clip)
                begin
                    status      = ST_TOO_LONG;
                    attempt_end = 1'b1;
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                end
            end
            PH_GAP:
            begin
                count_next = count_inc;
                if (count_inc >= gap_clip)
                begin
                    to_next = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_TRIGGER;
                count_next = '0;
            end
        endcase

        // attempt over: gap, or straight on when the gap is zero
        if (attempt_end)
        begin
            count_next = '0;
            if (gap_clip == '0)
            begin
                to_next = 1'b1;
            end
            else
            begin
                phase_next = PH_GAP;
            end
        end

        if (to_next)
        begin
            phase_next  = PH_TRIGGER;
            count_next  = '0;
            sensor_next = (sensor_reg == LAST_SENSOR) ? '0 : sensor_reg + SW'(1);
        end
    end

    // state update on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TRIGGER;
            sensor_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            sensor_reg <= sensor_next;
            count_reg  <= count_next;
        end
    end

    // distance store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_N; k++)
            begin
                dist_reg[k] <= '0;
            end
        end
        else if (accept && store_en)
        begin
            for (int k = 0; k < STORE_N; k++)
            begin
                if (32'(sensor_reg) == k)
                begin
                    dist_reg[k] <= dist_new;
                end
            end
        end
    end

    // distances as seen after this tick, absent sensors read zero
    for (genvar g = 0; g < LINES_W; g++)
    begin : g_view
        if (g < STORE_N)
        begin : g_has
            assign dist_view[g] = (store_en && 32'(sensor_reg) == g) ? dist_new
                                                                     : dist_reg[g];
        end
        else
        begin : g_none
            assign dist_view[g] = '0;
        end
    end

    // result assembly
    always_comb
    begin
        out_next.trigger_lines  = (phase_reg == PH_TRIGGER) ? trig : '0;
        out_next.active_sensor  = 2'(sensor_reg);
        out_next.measure_done   = store_en;
        out_next.attempt_status = status;
        out_next.forward_cm_q8  = dist_view[0];
        out_next.left_cm_q8     = dist_view[1];
        out_next.right_cm_q8    = dist_view[2];
    end

    // result register, valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register, payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // served sensor always within the configured set
    a_sensor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sensor_reg) < NUM_SENSORS)
        else $error("sensor index out of range");

    // an accepted tick always leaves a result behind
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    // a stored distance is always reported as a good attempt
    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_reg.measure_done) |-> (out_reg.attempt_status == ST_OK))
        else $error("measure_done without ok status");

    // at most one trigger line, and never while an attempt is reported
    a_trig_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($onehot0(out_reg.trigger_lines)
            && (out_reg.trigger_lines == '0 || out_reg.attempt_status == ST_BUSY)))
        else $error("bad trigger drive");

    // state only moves on an accepted tick
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(sensor_reg) && $stable(count_reg)))
        else $error("state changed without a tick");
`endif

endmodule
